FILE: src/mf3_pkg.sv
// shared types, constants and compare functions for the 3x3 median filter
`default_nettype none

package mf3_pkg;

    localparam int PIX_W = 8;
    localparam int CNT_W = 10;
    localparam int CFG_W = 11;
    localparam int MAX_DIM = 1024;
    localparam int MIN_DIM = 3;
    localparam int DIM_RESET = 400;

    // register indexes on the configuration port
    localparam logic REG_FRAME_WIDTH = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // one column of the window, sorted
    typedef struct packed {
        pix_t hi;
        pix_t mid;
        pix_t lo;
    } col_t;

    // what a request produces downstream
    typedef struct packed {
        logic has_med;
        logic border;
    } flags_t;

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
        col_t s;
        s.lo = min2(min2(a, b), c);
        s.hi = max2(max2(a, b), c);
        s.mid = med3(a, b, c);
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: src/mf3_ram.sv
// generic single write port ram with registered read
`default_nettype none

module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/mf3_median.sv
// median of nine from three pre-sorted window columns
`default_nettype none

module mf3_median
    import mf3_pkg::*;
(
    input  wire col_t col0,
    input  wire col_t col1,
    input  wire col_t col2,
    output pix_t      med
);

    pix_t lo_max;
    pix_t mid_med;
    pix_t hi_min;

    // the median is the median of: largest low, middle mid, smallest high
    always_comb
    begin
        lo_max = max2(max2(col0.lo, col1.lo), col2.lo);
        mid_med = med3(col0.mid, col1.mid, col2.mid);
        hi_min = min2(min2(col0.hi, col1.hi), col2.hi);
        med = med3(lo_max, mid_med, hi_min);
    end

endmodule

`default_nettype wire

FILE: src/mf3_out.sv
// output register: emits the median and/or border copy of one request
`default_nettype none

module mf3_out
    import mf3_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   load_valid,
    output logic        load_ready,
    input  wire pix_t   load_med,
    input  wire pix_t   load_pix,
    input  wire cnt_t   load_row,
    input  wire cnt_t   load_col,
    input  wire flags_t load_flags,
    output logic        out_valid,
    input  wire logic   out_ready,
    output pix_t        pixel_out,
    output cnt_t        out_row,
    output cnt_t        out_col,
    output logic        last
);

    logic   valid_reg;
    logic   phase_reg;
    flags_t flags_reg;
    pix_t   med_reg;
    pix_t   pix_reg;
    cnt_t   row_reg;
    cnt_t   col_reg;
    cnt_t   mrow_reg;
    cnt_t   mcol_reg;

    logic show_med;
    logic finish;

    assign show_med = flags_reg.has_med && !phase_reg;
    assign finish = valid_reg && out_ready && !(show_med && flags_reg.border);
    assign load_ready = !valid_reg || finish;

    assign out_valid = valid_reg;
    assign pixel_out = show_med ? med_reg : pix_reg;
    assign out_row = show_med ? mrow_reg : row_reg;
    assign out_col = show_med ? mcol_reg : col_reg;
    assign last = !show_med || !flags_reg.border;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
            flags_reg <= '0;
        end
        else if (load_valid && load_ready)
        begin
            valid_reg <= 1'b1;
            phase_reg <= 1'b0;
            flags_reg <= load_flags;
        end
        else if (valid_reg && out_ready)
        begin
            if (show_med && flags_reg.border)
            begin
                phase_reg <= 1'b1;
            end
            else
            begin
                valid_reg <= 1'b0;
                phase_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            med_reg <= load_med;
            pix_reg <= load_pix;
            row_reg <= load_row;
            col_reg <= load_col;
            mrow_reg <= load_row - cnt_t'(1);
            mcol_reg <= load_col - cnt_t'(1);
        end
    end

    // second half of a two-result request only exists after a median
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> valid_reg && flags_reg.has_med && flags_reg.border)
        else $error("border phase without pending median");

    // a result not marked last is always followed by another one
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_ready && !last |=> valid_reg && phase_reg)
        else $error("missing second result");

    // a held request always carries at least one result
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> flags_reg.has_med || flags_reg.border)
        else $error("empty request in output register");

endmodule

`default_nettype wire

FILE: src/median_filter_3x3.sv
// top level of the streaming 3x3 median filter
// usage:
//   pixels enter in raster order on pixel_in with in_valid/in_ready; results
//   leave on pixel_out/out_row/out_col/last with out_valid/out_ready.
//   frame size is set through cfg_we/cfg_index/cfg_data while the block is idle;
//   index 0 is the width, index 1 the height, both clamped to 3..1024.
//   each request gives zero, one or two results: the median of (r-1,c-1) once
//   pixel (r,c) completes its neighborhood, then the copy of (r,c) if it lies on
//   the frame border; last marks the final result of a request.
// timing:
//   a request passes through the line store read, then column sort and window,
//   then median into the output register, where its result becomes valid.
//   one request per cycle while out_ready stays high and no request has two
//   results; such a request holds the output register until both have left, so the
//   input can stall on the bottom row from column 2 and the last column from row 2 on.
// reset:
//   counters, window and pipeline valids clear; frame size returns to 400x400.
//   the line stores need no clearing since the first two rows only pass through.
// stall:
//   requests without a result keep draining while out_ready is low; in_ready
//   drops once output register and stage 2 hold results and stage 1 is occupied.
`default_nettype none

module median_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       pixel_in,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [7:0]       pixel_out,
    output logic      [9:0]       out_row,
    output logic      [9:0]       out_col,
    output logic                  last,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WCAP = (MAX_WIDTH < MAX_DIM) ? MAX_WIDTH : MAX_DIM;

    // configuration, held as last column and last row index
    cnt_t last_col_reg;
    cnt_t last_row_reg;
    logic [CFG_W-1:0] w_clamp;
    logic [CFG_W-1:0] h_clamp;

    always_comb
    begin
        w_clamp = cfg_data;
        if (cfg_data < CFG_W'(MIN_DIM))
        begin
            w_clamp = CFG_W'(MIN_DIM);
        end
        else if (cfg_data > CFG_W'(WCAP))
        begin
            w_clamp = CFG_W'(WCAP);
        end
        h_clamp = cfg_data;
        if (cfg_data < CFG_W'(MIN_DIM))
        begin
            h_clamp = CFG_W'(MIN_DIM);
        end
        else if (cfg_data > CFG_W'(MAX_DIM))
        begin
            h_clamp = CFG_W'(MAX_DIM);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= cnt_t'(DIM_RESET - 1);
            last_row_reg <= cnt_t'(DIM_RESET - 1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  last_col_reg <= cnt_t'(w_clamp - CFG_W'(1));
                REG_FRAME_HEIGHT: last_row_reg <= cnt_t'(h_clamp - CFG_W'(1));
                default:          last_col_reg <= last_col_reg;
            endcase
        end
    end

    // handshake between stages
    logic accept;
    logic adv1;
    logic adv2;
    logic out_load_ready;
    logic s2_has_result;

    // position counters and request classification
    cnt_t   row_cnt_reg;
    cnt_t   col_cnt_reg;
    logic   at_last_col;
    logic   at_last_row;
    flags_t in_flags;

    assign at_last_col = col_cnt_reg >= last_col_reg;
    assign at_last_row = row_cnt_reg >= last_row_reg;

    always_comb
    begin
        in_flags.has_med = (row_cnt_reg >= cnt_t'(2)) && (col_cnt_reg >= cnt_t'(2));
        in_flags.border = (row_cnt_reg == '0) || (col_cnt_reg == '0)
                          || at_last_row || at_last_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (at_last_col)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= at_last_row ? '0 : row_cnt_reg + cnt_t'(1);
            end
            else
            begin
                col_cnt_reg <= col_cnt_reg + cnt_t'(1);
            end
        end
    end

    // stage 1: request waits for the line store read
    logic          s1_valid_reg;
    pix_t          s1_pix_reg;
    cnt_t          s1_row_reg;
    cnt_t          s1_col_reg;
    flags_t        s1_flags_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [AW-1:0] rd_addr;
    logic [2*PIX_W-1:0] ls_rdata;
    logic [2*PIX_W-1:0] ls_wdata;

    assign in_ready = !s1_valid_reg || adv1;
    assign accept = in_valid && in_ready;
    assign rd_addr = AW'(col_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv1)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= pixel_in;
            s1_row_reg <= row_cnt_reg;
            s1_col_reg <= col_cnt_reg;
            s1_flags_reg <= in_flags;
            s1_addr_reg <= rd_addr;
        end
    end

    // upper byte holds row r-2, lower byte row r-1; shift down as the row passes
    assign ls_wdata = {ls_rdata[PIX_W-1:0], s1_pix_reg};

    mf3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (adv1),
        .waddr (s1_addr_reg),
        .wdata (ls_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ls_rdata)
    );

    // stage 2: sorted window columns, newest in win0
    logic   s2_valid_reg;
    pix_t   s2_pix_reg;
    cnt_t   s2_row_reg;
    cnt_t   s2_col_reg;
    flags_t s2_flags_reg;
    col_t   win0_reg;
    col_t   win1_reg;
    col_t   win2_reg;
    pix_t   s2_med;

    assign s2_has_result = s2_flags_reg.has_med || s2_flags_reg.border;
    assign adv2 = s2_valid_reg && (!s2_has_result || out_load_ready);
    assign adv1 = s1_valid_reg && (!s2_valid_reg || adv2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            win0_reg <= '0;
            win1_reg <= '0;
            win2_reg <= '0;
        end
        else if (adv1)
        begin
            s2_valid_reg <= 1'b1;
            win0_reg <= sort3(ls_rdata[2*PIX_W-1:PIX_W], ls_rdata[PIX_W-1:0], s1_pix_reg);
            win1_reg <= win0_reg;
            win2_reg <= win1_reg;
        end
        else if (adv2)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s2_pix_reg <= s1_pix_reg;
            s2_row_reg <= s1_row_reg;
            s2_col_reg <= s1_col_reg;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    mf3_median u_median (
        .col0 (win0_reg),
        .col1 (win1_reg),
        .col2 (win2_reg),
        .med  (s2_med)
    );

    mf3_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (s2_valid_reg && s2_has_result),
        .load_ready (out_load_ready),
        .load_med   (s2_med),
        .load_pix   (s2_pix_reg),
        .load_row   (s2_row_reg),
        .load_col   (s2_col_reg),
        .load_flags (s2_flags_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .out_row    (out_row),
        .out_col    (out_col),
        .last       (last)
    );

    // a median is only scheduled once two rows and two columns have passed
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_flags_reg.has_med |->
            s1_row_reg >= cnt_t'(2) && s1_col_reg >= cnt_t'(2))
        else $error("median scheduled too early");

    // back pressure reaches the input only through a full stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && s2_valid_reg)
        else $error("input stalled with free stage");

    // a taken request always lands in stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted request lost");

endmodule

`default_nettype wire
